// ===== src/deadline_timer_queue_defines.svh =====
// Assertion macros used by the checker of the timer queue.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Plain concurrent check under the asynchronous reset.
`define DTQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition seen in one cycle implies another in the next cycle.
`define DTQ_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== src/dtq_pkg.sv =====
package dtq_pkg;

	localparam int CAPACITY = 16;
	localparam int TIME_BITS = 32;
	localparam int MAX_RESULTS = 16;
	localparam int FIFO_DEPTH = 2;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = ((TIME_BITS > 20) ? TIME_BITS : 20) + 1;
	localparam int FPTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [TIME_BITS-1:0] time_t;

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_REJECTED = 2'd1;
	localparam logic [1:0] KIND_FIRED = 2'd2;

	typedef struct packed {
		logic cmd;
		logic [15:0] task_id;
		time_t deadline;
		time_t now;
	} cmd_t;

endpackage

// ===== src/dtq_if.sv =====
interface dtq_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [15:0] task_id;
	logic [19:0] delay_ticks;
	logic [31:0] now_time;

	modport source (output valid, cmd, task_id, delay_ticks, now_time, input ready);
	modport sink (input valid, cmd, task_id, delay_ticks, now_time, output ready);
endinterface

interface dtq_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [15:0] fired_task;
	logic [31:0] deadline;
	logic [4:0] pending_count;
	logic last;

	modport source (output valid, kind, fired_task, deadline, pending_count, last,
		input ready);
	modport sink (input valid, kind, fired_task, deadline, pending_count, last,
		output ready);
endinterface

// ===== src/dtq_front.sv =====
module dtq_front (
	dtq_req_if.sink req,
	input logic fifo_full,
	output logic push,
	output dtq_pkg::cmd_t push_data
);

	localparam logic [dtq_pkg::SUM_W-1:0] TIME_MAX =
		dtq_pkg::SUM_W'({dtq_pkg::TIME_BITS{1'b1}});

	logic [dtq_pkg::SUM_W-1:0] sum;
	dtq_pkg::time_t now;

	assign now = dtq_pkg::TIME_BITS'(req.now_time);
	assign sum = dtq_pkg::SUM_W'(now) + dtq_pkg::SUM_W'(req.delay_ticks);

	assign req.ready = !fifo_full;
	assign push = req.valid && !fifo_full;

	always_comb begin
		push_data.cmd = req.cmd;
		push_data.task_id = req.task_id;
		push_data.now = now;
		// The deadline saturates at the largest representable time.
		if (sum > TIME_MAX) begin
			push_data.deadline = {dtq_pkg::TIME_BITS{1'b1}};
		end else begin
			push_data.deadline = dtq_pkg::TIME_BITS'(sum);
		end
	end

endmodule

// ===== src/dtq_fifo.sv =====
module dtq_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dtq_pkg::cmd_t push_data,
	input logic pop,
	output logic full,
	output logic nonempty,
	output dtq_pkg::cmd_t head
);

	dtq_pkg::cmd_t mem_q [dtq_pkg::FIFO_DEPTH];
	logic [dtq_pkg::FPTR_W-1:0] wptr_q, rptr_q;
	logic [dtq_pkg::FCNT_W-1:0] cnt_q;

	function automatic logic [dtq_pkg::FPTR_W-1:0] inc(logic [dtq_pkg::FPTR_W-1:0] p);
		if (p == dtq_pkg::FPTR_W'(dtq_pkg::FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full = (cnt_q == dtq_pkg::FCNT_W'(dtq_pkg::FIFO_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= inc(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/dtq_back.sv =====
module dtq_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input dtq_pkg::cmd_t cmd,
	output logic pop,
	dtq_rsp_if.source rsp
);

	localparam int C = dtq_pkg::CAPACITY;
	localparam int CW = dtq_pkg::CNT_W;
	localparam int IW = dtq_pkg::IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIRE = 3'b100
	} state_t;

	state_t state_q;
	dtq_pkg::time_t dl_q [C];
	logic [15:0] task_q [C];
	logic [CW-1:0] count_q, idx_q, match_q, fired_q, total;
	dtq_pkg::time_t best_q, now_q;

	logic out_valid_q;
	logic [1:0] kind_q;
	logic [15:0] task_out_q;
	dtq_pkg::time_t dl_out_q;
	logic [CW-1:0] pend_q;
	logic last_q;

	logic slot_free, do_sched, do_fire, is_match, full, out_load;
	dtq_pkg::time_t cur_dl;

	assign slot_free = !out_valid_q || rsp.ready;
	assign full = (count_q == CW'(C));
	assign cur_dl = dl_q[idx_q[IW-1:0]];
	assign is_match = (cur_dl == best_q);
	assign total = (match_q > CW'(dtq_pkg::MAX_RESULTS)) ? CW'(dtq_pkg::MAX_RESULTS) : match_q;

	// A schedule command is taken only when its result can be registered.
	assign pop = (state_q == ST_IDLE) && cmd_valid &&
		((cmd.cmd == dtq_pkg::CMD_TICK) || slot_free);
	assign do_sched = pop && (cmd.cmd == dtq_pkg::CMD_SCHEDULE) && !full;
	assign do_fire = (state_q == ST_FIRE) && is_match && slot_free;
	assign out_load = (pop && cmd.cmd == dtq_pkg::CMD_SCHEDULE) || do_fire;

	assign rsp.valid = out_valid_q;
	assign rsp.kind = kind_q;
	assign rsp.fired_task = task_out_q;
	assign rsp.deadline = 32'(dl_out_q);
	assign rsp.pending_count = 5'(pend_q);
	assign rsp.last = last_q;

	always_ff @(posedge clk) begin
		if (do_sched) begin
			dl_q[count_q[IW-1:0]] <= cmd.deadline;
			task_q[count_q[IW-1:0]] <= cmd.task_id;
		end else if (do_fire) begin
			// Entries are kept in insertion order; removal closes the gap.
			for (int j = 0; j < C - 1; j++) begin
				if (CW'(j) >= idx_q) begin
					dl_q[j] <= dl_q[j+1];
					task_q[j] <= task_q[j+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.cmd == dtq_pkg::CMD_SCHEDULE) begin
			kind_q <= full ? dtq_pkg::KIND_REJECTED : dtq_pkg::KIND_ACCEPTED;
			task_out_q <= cmd.task_id;
			dl_out_q <= cmd.deadline;
			pend_q <= full ? count_q : count_q + 1'b1;
			last_q <= 1'b1;
		end else if (do_fire) begin
			kind_q <= dtq_pkg::KIND_FIRED;
			task_out_q <= task_q[idx_q[IW-1:0]];
			dl_out_q <= best_q;
			pend_q <= count_q - 1'b1;
			last_q <= (fired_q + 1'b1 == total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			match_q <= '0;
			fired_q <= '0;
			best_q <= '0;
			now_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (pop && cmd.cmd == dtq_pkg::CMD_SCHEDULE) begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end else if (pop && count_q != '0) begin
						best_q <= dl_q[0];
						match_q <= CW'(1);
						idx_q <= CW'(1);
						now_q <= cmd.now;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == count_q) begin
						idx_q <= '0;
						fired_q <= '0;
						state_q <= (best_q > now_q) ? ST_IDLE : ST_FIRE;
					end else begin
						if (cur_dl < best_q) begin
							best_q <= cur_dl;
							match_q <= CW'(1);
						end else if (is_match) begin
							match_q <= match_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIRE: begin
					if (!is_match) begin
						idx_q <= idx_q + 1'b1;
					end else if (slot_free) begin
						count_q <= count_q - 1'b1;
						fired_q <= fired_q + 1'b1;
						if (fired_q + 1'b1 == total) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/deadline_timer_queue.sv =====
// One-shot timer queue for up to CAPACITY tasks. A schedule transfer stores a task whose
// deadline is now_time plus delay_ticks, saturating at the largest time, and always returns
// exactly one result, marked rejected when the table is full. The front stage computes the
// deadline in the cycle of the input transfer and writes the command into a two-entry queue;
// the table controller takes it when idle and registers the result, so a schedule result
// passes through a queue entry and the result register. A tick transfer makes the controller
// scan the stored deadlines one per cycle to find the earliest and count its group. If it
// is due, a release pass walks the table in insertion order, one entry per cycle unless a
// due entry waits for the result channel, and emits each task with that deadline as it is
// reached, the last one marked; nothing is emitted when the table is empty or nothing is
// due. The scan, the release walk and stalls on the result channel set the time a tick
// takes; while they run the command queue fills and then holds off the input.
module deadline_timer_queue (
	input logic clk,
	input logic arst_n,
	dtq_req_if.sink req,
	dtq_rsp_if.source rsp
);

	logic push, pop, fifo_full, fifo_nonempty;
	dtq_pkg::cmd_t push_data, head;

	dtq_front u_front (
		.req(req),
		.fifo_full(fifo_full),
		.push(push),
		.push_data(push_data)
	);

	dtq_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.full(fifo_full),
		.nonempty(fifo_nonempty),
		.head(head)
	);

	dtq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(fifo_nonempty),
		.cmd(head),
		.pop(pop),
		.rsp(rsp)
	);

endmodule

// ===== src/dtq_checker.sv =====
`include "deadline_timer_queue_defines.svh"

module dtq_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_kind,
	input logic [4:0] rsp_pending_count,
	input logic rsp_last
);

	logic kind_ok, sched_last_ok, reject_ok;

	assign kind_ok = (rsp_kind == dtq_pkg::KIND_ACCEPTED) ||
		(rsp_kind == dtq_pkg::KIND_REJECTED) || (rsp_kind == dtq_pkg::KIND_FIRED);
	assign sched_last_ok = (rsp_kind == dtq_pkg::KIND_FIRED) || rsp_last;
	assign reject_ok = (rsp_kind != dtq_pkg::KIND_REJECTED) ||
		(rsp_pending_count == 5'(dtq_pkg::CAPACITY));

	`DTQ_ASSERT(a_kind_legal, !rsp_valid || kind_ok, "illegal result kind")
	`DTQ_ASSERT(a_sched_last, !rsp_valid || sched_last_ok, "schedule result not last")
	`DTQ_ASSERT(a_reject_full, !rsp_valid || reject_ok, "reject while not full")
	`DTQ_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_pending_count), "stalled result changed")

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_kind(rsp.kind),
	.rsp_pending_count(rsp.pending_count),
	.rsp_last(rsp.last)
);

// ===== dv/deadline_timer_queue_tb_pkg.sv =====
`timescale 1ns / 1ps
package deadline_timer_queue_tb_pkg;

	typedef struct {
		logic [1:0] kind;
		logic [15:0] task_id;
		logic [31:0] deadline;
		logic [4:0] pending;
		logic last;
	} timer_result_t;

	class timer_scoreboard;
		bit slot_live[dtq_pkg::CAPACITY];
		logic [31:0] slot_deadline[dtq_pkg::CAPACITY];
		logic [15:0] slot_task[dtq_pkg::CAPACITY];
		int slot_rank[dtq_pkg::CAPACITY];
		int live_count;
		timer_result_t due_results[$];
		int errors;
		int n_fired;
		int n_rejected;
		int n_accepted;

		function void note_input(logic cmd, logic [15:0] task_id, logic [19:0] delay,
			logic [31:0] now);
			logic [32:0] sum;
			logic [31:0] dl;
			logic [31:0] best;
			timer_result_t r;
			int slot;
			int pick;
			int released;
			bit any;
			if (cmd == dtq_pkg::CMD_SCHEDULE) begin
				sum = {1'b0, now} + {13'd0, delay};
				dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				slot = -1;
				for (int i = 0; i < dtq_pkg::CAPACITY; i++)
					if (!slot_live[i] && slot < 0) slot = i;
				r.task_id = task_id;
				r.deadline = dl;
				r.last = 1'b1;
				if (slot < 0) begin
					r.kind = dtq_pkg::KIND_REJECTED;
				end else begin
					slot_live[slot] = 1'b1;
					slot_deadline[slot] = dl;
					slot_task[slot] = task_id;
					slot_rank[slot] = live_count;
					live_count++;
					r.kind = dtq_pkg::KIND_ACCEPTED;
				end
				r.pending = 5'(live_count);
				due_results.insert(due_results.size(), r);
				return;
			end
			any = 1'b0;
			best = '0;
			for (int i = 0; i < dtq_pkg::CAPACITY; i++)
				if (slot_live[i] && (!any || slot_deadline[i] < best)) begin
					best = slot_deadline[i];
					any = 1'b1;
				end
			if (!any || best > now) return;
			released = 0;
			while (released < dtq_pkg::MAX_RESULTS) begin
				pick = -1;
				for (int i = 0; i < dtq_pkg::CAPACITY; i++)
					if (slot_live[i] && slot_deadline[i] == best &&
						(pick < 0 || slot_rank[i] < slot_rank[pick])) pick = i;
				if (pick < 0) break;
				slot_live[pick] = 1'b0;
				for (int i = 0; i < dtq_pkg::CAPACITY; i++)
					if (slot_live[i] && slot_rank[i] > slot_rank[pick]) slot_rank[i]--;
				live_count--;
				r.kind = dtq_pkg::KIND_FIRED;
				r.task_id = slot_task[pick];
				r.deadline = best;
				r.pending = 5'(live_count);
				r.last = 1'b0;
				due_results.insert(due_results.size(), r);
				released++;
			end
			due_results[$].last = 1'b1;
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result kind=%0d task=%0h", got.kind, got.task_id);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.kind == dtq_pkg::KIND_FIRED) n_fired++;
			else if (got.kind == dtq_pkg::KIND_REJECTED) n_rejected++;
			else n_accepted++;
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.task_id !== want.task_id) begin
				$error("fired_task: expected %0h, got %0h", want.task_id, got.task_id);
				errors++;
			end
			if (got.deadline !== want.deadline) begin
				$error("deadline: expected %0h, got %0h", want.deadline, got.deadline);
				errors++;
			end
			if (got.pending !== want.pending) begin
				$error("pending_count: expected %0d, got %0d", want.pending, got.pending);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass
endpackage

// ===== dv/tb_deadline_timer_queue.sv =====
`timescale 1ns / 1ps
module tb_deadline_timer_queue;

	logic clk;
	logic arst_n;
	dtq_req_if req ();
	dtq_rsp_if rsp ();

	deadline_timer_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	deadline_timer_queue_tb_pkg::timer_scoreboard timers = new();
	logic [31:0] clock_now;
	bit hold_off;
	bit stim_done;
	int n_schedules;
	int n_ticks;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send(logic cmd, logic [15:0] task_id, logic [19:0] delay,
		logic [31:0] now);
		int g;
		g = stim_done ? 0 : gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			req.cmd <= 1'($urandom_range(0, 1));
			req.task_id <= 16'($urandom);
			req.delay_ticks <= 20'($urandom);
			req.now_time <= $urandom;
			repeat (g) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.task_id <= task_id;
		req.delay_ticks <= delay;
		req.now_time <= now;
		do @(posedge clk); while (!req.ready);
		timers.note_input(cmd, task_id, delay, now);
		if (cmd == dtq_pkg::CMD_TICK) n_ticks++;
		else n_schedules++;
		@(negedge clk);
	endtask

	task automatic schedule(logic [15:0] task_id, logic [19:0] delay);
		send(dtq_pkg::CMD_SCHEDULE, task_id, delay, clock_now);
	endtask

	task automatic tick(logic [31:0] now);
		clock_now = now;
		send(dtq_pkg::CMD_TICK, 16'($urandom), 20'($urandom), now);
	endtask

	// The receiver stalls at random; during a hold-off it stays low so results back up and the input is held off.
	initial begin
		int g;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
			end else begin
				g = gap_len();
				if (g == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		deadline_timer_queue_tb_pkg::timer_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.kind = rsp.kind;
			got.task_id = rsp.fired_task;
			got.deadline = rsp.deadline;
			got.pending = rsp.pending_count;
			got.last = rsp.last;
			timers.check_result(got);
		end
	end

	initial begin
		#20ms;
		$display("deadline_timer_queue: mismatch");
		$finish;
	end

	initial begin
		int n;
		int waited;
		logic [31:0] base;
		req.valid = 1'b0;
		req.cmd = dtq_pkg::CMD_SCHEDULE;
		req.task_id = '0;
		req.delay_ticks = '0;
		req.now_time = '0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		clock_now = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty tick, zero delay, saturation, full table, a large group.
		tick(32'd0);
		schedule(16'h0000, 20'd0);
		tick(32'd0);
		clock_now = 32'hFFFF_FFF0;
		schedule(16'hFFFF, 20'hFFFFF);
		clock_now = 32'd100;
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 16; i++) schedule(16'(16'h100 + i), 20'd50);
		join
		tick(32'd149);
		tick(32'd150);
		tick(32'hFFFF_FFFF);
		tick(32'hFFFF_FFFF);

		// Random: bursts of schedules followed by ticks that move time forward or jump to a random time.
		base = $urandom;
		n = 0;
		while (n < 185) begin
			clock_now = base;
			for (int k = $urandom_range(1, 18); k > 0; k--) begin
				if ($urandom_range(0, 9) < 7)
					schedule(16'($urandom), 20'($urandom_range(0, 40)));
				else
					schedule(16'($urandom), 20'($urandom));
				n++;
			end
			for (int k = $urandom_range(1, 8); k > 0; k--) begin
				if ($urandom_range(0, 9) == 0) base = $urandom;
				else base = base + $urandom_range(0, 25);
				tick(base);
				n++;
			end
		end
		if ($urandom_range(0, 1)) tick(32'hFFFF_FFFF);
		stim_done = 1'b1;
		req.valid <= 1'b0;

		waited = 0;
		while (timers.due_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d schedules and %0d ticks; %0d fired, %0d accepted, %0d rejected.",
			n_schedules, n_ticks, timers.n_fired, timers.n_accepted, timers.n_rejected);
		if (timers.errors == 0 && timers.due_results.size() == 0) begin
			$display("deadline_timer_queue: match");
		end else begin
			$display("deadline_timer_queue: mismatch");
		end
		$finish;
	end
endmodule

// ===== deadline_timer_queue.f =====
+incdir+src
src/dtq_pkg.sv
src/dtq_if.sv
src/dtq_front.sv
src/dtq_fifo.sv
src/dtq_back.sv
src/deadline_timer_queue.sv
src/dtq_checker.sv
dv/deadline_timer_queue_tb_pkg.sv
dv/tb_deadline_timer_queue.sv
